/* src/glr_pkg.sv */
// ----------------------------------------------------------------------------
// glr_pkg
// Shared constants and types for the glyph range map lookup block.
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

  localparam int MAX_RANGES = 16;
  localparam int CUR_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int LIVE_W     = $clog2(MAX_RANGES + 1);

  localparam int CODE_W  = 16;
  localparam int SLOT_W  = 4;
  localparam int GLYPH_W = 16;
  localparam int RCNT_W  = 5;
  localparam int OFF_W   = 18;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 16;

  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_WRITE  = 1'b1;

  localparam logic CFG_RANGE_COUNT = 1'b0;
  localparam logic CFG_GLYPH_COUNT = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] last;
    logic [CODE_W-1:0] first;
  } range_entry_t;

endpackage

`default_nettype wire

/* src/glyph_range_map_lookup.sv */
// ----------------------------------------------------------------------------
// glyph_range_map_lookup
// Code point to glyph index lookup over a sorted range table held in RAM.
// ----------------------------------------------------------------------------
// Lookup: the cursor entry is read from the table RAM and checked in S_LOOK,
//   again per range stepped over; S_FIN loads the result once output is free.
// Write item: RAM write, read of entry 0, offset reload.
// One item at a time; throughput is set by the walk loop around the table RAM.
// Reset clears cursor, offset, output valid and sets both counts to 1;
//   table contents are undefined until written.
`default_nettype none

module glyph_range_map_lookup
  import glr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // tdata: code_point[15:0], range_slot[19:16], range_first[35:20],
  //        range_last[51:36], zero pad[55:52]
  input  wire logic                 s_axis_tvalid_i,
  output logic                      s_axis_tready_o,
  input  wire logic [S_TDATA_W-1:0] s_axis_tdata_i,
  input  wire logic                 s_axis_tuser_i,   // cmd
  // tdata: glyph_index[15:0]
  output logic                      m_axis_tvalid_o,
  input  wire logic                 m_axis_tready_i,
  output logic      [M_TDATA_W-1:0] m_axis_tdata_o,
  output logic                      m_axis_tuser_o,   // found
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic                 cfg_addr_i,
  input  wire logic [GLYPH_W-1:0]   cfg_data_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_FIN  = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_WRLD = 3'd4;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DN   = 2'd2;

  logic [2:0]         state_q, state_d;
  logic [1:0]         dir_q, dir_d;
  logic [CUR_W-1:0]   cursor_q, cursor_d;
  logic [OFF_W-1:0]   offset_q, offset_d;
  logic [CODE_W-1:0]  code_q, code_d;
  logic               hit_q, hit_d;
  logic [RCNT_W-1:0]  range_count_q;
  logic [GLYPH_W-1:0] glyph_count_q;
  logic               m_valid_q, m_valid_d;
  logic [GLYPH_W-1:0] m_index_q, m_index_d;
  logic               m_found_q, m_found_d;

  logic [CODE_W-1:0]  in_code, in_first, in_last;
  logic [SLOT_W-1:0]  in_slot;
  logic               s_fire, slot_ok;
  logic [CUR_W-1:0]   cur_fix, raddr;
  logic               ram_we;
  range_entry_t       wentry, rentry;
  logic [LIVE_W-1:0]  live;
  logic               can_up, gt, lt;
  logic [OFF_W-1:0]   off_eff;
  logic [OFF_W:0]     gsum;
  logic               g_ok, out_load;

  assign in_code  = s_axis_tdata_i[15:0];
  assign in_slot  = s_axis_tdata_i[19:16];
  assign in_first = s_axis_tdata_i[35:20];
  assign in_last  = s_axis_tdata_i[51:36];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_ok         = 32'(in_slot) < MAX_RANGES;
  assign cfg_ready_o     = 1'b1;

  assign cur_fix = (32'(cursor_q) >= MAX_RANGES) ? '0 : cursor_q;

  assign ram_we       = s_fire && (s_axis_tuser_i == CMD_WRITE) && slot_ok;
  assign wentry.first = in_first;
  assign wentry.last  = in_last;

  glr_ram #(
    .Width($bits(range_entry_t)),
    .Depth(MAX_RANGES)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(CUR_W'(in_slot)),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rentry)
  );

  always_comb begin
    if (range_count_q == '0) begin
      live = LIVE_W'(1);
    end else if (32'(range_count_q) > MAX_RANGES) begin
      live = LIVE_W'(MAX_RANGES);
    end else begin
      live = LIVE_W'(range_count_q);
    end
  end

  assign can_up = (LIVE_W'(cursor_q) + LIVE_W'(1)) < live;
  assign gt     = code_q > rentry.last;
  assign lt     = code_q < rentry.first;

  always_comb begin
    case (dir_q)
      DIR_UP:  off_eff = offset_q - {2'b00, rentry.first};
      DIR_DN:  off_eff = offset_q - ({2'b00, rentry.last} + OFF_W'(1));
      default: off_eff = offset_q;
    endcase
  end

  assign gsum     = {3'b000, code_q} + {offset_q[OFF_W-1], offset_q};
  assign g_ok     = !gsum[OFF_W] && (gsum[OFF_W-1:0] < {2'b00, glyph_count_q});
  assign out_load = (state_q == S_FIN) && (!m_valid_q || m_axis_tready_i);

  always_comb begin
    state_d   = state_q;
    dir_d     = dir_q;
    cursor_d  = cursor_q;
    offset_d  = offset_q;
    code_d    = code_q;
    hit_d     = hit_q;
    raddr     = cursor_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_index_d = m_index_q;
    m_found_d = m_found_q;
    case (state_q)
      S_IDLE: begin
        raddr = cur_fix;
        if (s_fire) begin
          if (s_axis_tuser_i == CMD_LOOKUP) begin
            cursor_d = cur_fix;
            code_d   = in_code;
            dir_d    = DIR_NONE;
            state_d  = S_LOOK;
          end else if (slot_ok) begin
            cursor_d = '0;
            state_d  = S_WR;
          end
        end
      end
      S_LOOK: begin
        offset_d = off_eff;
        hit_d    = 1'b0;
        state_d  = S_FIN;
        if ((dir_q == DIR_UP) && lt) begin
          hit_d = 1'b0;
        end else if ((dir_q == DIR_DN) && gt) begin
          hit_d = 1'b0;
        end else if (gt) begin
          if (can_up) begin
            offset_d = off_eff + {2'b00, rentry.last} + OFF_W'(1);
            cursor_d = cursor_q + CUR_W'(1);
            raddr    = cursor_q + CUR_W'(1);
            dir_d    = DIR_UP;
            state_d  = S_LOOK;
          end
        end else if (lt) begin
          if (cursor_q != '0) begin
            offset_d = off_eff + {2'b00, rentry.first};
            cursor_d = cursor_q - CUR_W'(1);
            raddr    = cursor_q - CUR_W'(1);
            dir_d    = DIR_DN;
            state_d  = S_LOOK;
          end
        end else begin
          hit_d = 1'b1;
        end
      end
      S_FIN: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          m_found_d = hit_q && g_ok;
          m_index_d = (hit_q && g_ok) ? gsum[GLYPH_W-1:0] : glyph_count_q - GLYPH_W'(1);
          state_d   = S_IDLE;
        end
      end
      S_WR: begin
        raddr   = '0;
        state_d = S_WRLD;
      end
      S_WRLD: begin
        offset_d = OFF_W'(0) - {2'b00, rentry.first};
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      dir_q         <= DIR_NONE;
      cursor_q      <= '0;
      offset_q      <= '0;
      hit_q         <= 1'b0;
      m_valid_q     <= 1'b0;
      range_count_q <= RCNT_W'(1);
      glyph_count_q <= GLYPH_W'(1);
    end else begin
      state_q   <= state_d;
      dir_q     <= dir_d;
      cursor_q  <= cursor_d;
      offset_q  <= offset_d;
      hit_q     <= hit_d;
      m_valid_q <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          CFG_RANGE_COUNT: range_count_q <= cfg_data_i[RCNT_W-1:0];
          CFG_GLYPH_COUNT: glyph_count_q <= cfg_data_i;
          default:         range_count_q <= range_count_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q    <= code_d;
    m_index_q <= m_index_d;
    m_found_q <= m_found_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_index_q;
  assign m_axis_tuser_o  = m_found_q;

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) < MAX_RANGES)
    else $error("cursor beyond table");

  a_up_not_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && dir_q == DIR_UP) |-> cursor_q != '0)
    else $error("upward step landed on entry 0");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q) == S_FIN)
    else $error("result loaded outside finish state");

  a_write_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> (state_q == S_WR && cursor_q == '0) ##1 state_q == S_WRLD)
    else $error("write item did not rewind cursor");

endmodule

`default_nettype wire

/* src/glr_ram.sv */
// ----------------------------------------------------------------------------
// glr_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                          wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* test/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for glyph_range_map_lookup. Sends range table
// writes and code point lookups over the input stream. A cycle-free model of
// the range walk, with its own copy of the table, cursor and offset, predicts
// each lookup result. The output stream is compared in order against these
// predictions. Directed checks of table edges, gaps, glyph count and range
// count limits come first. Randomized traffic follows, on ordered and
// malformed tables, with paced input, output stalls and one long output
// hold-off.
// ----------------------------------------------------------------------------

module tb_top;
  import glr_pkg::*;

  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 400;

  typedef struct packed {
    logic              cmd;
    logic [CODE_W-1:0] code;
    logic [SLOT_W-1:0] slot;
    logic [CODE_W-1:0] first;
    logic [CODE_W-1:0] last;
  } glr_item_t;

  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic               found;
  } glyph_res_t;

  logic                 clk_i = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 s_valid = 1'b0;
  logic [S_TDATA_W-1:0] s_data = '0;
  logic                 s_user = 1'b0;
  logic                 m_ready = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_addr = 1'b0;
  logic [GLYPH_W-1:0]   cfg_data = '0;

  logic                 s_axis_tready_o;
  logic                 m_axis_tvalid_o;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;
  logic                 m_axis_tuser_o;
  logic                 cfg_ready_o;

  glyph_range_map_lookup u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr),
    .cfg_data_i      (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  // Model state
  logic [CODE_W-1:0]  span_first [MAX_RANGES];
  logic [CODE_W-1:0]  span_last  [MAX_RANGES];
  logic [CUR_W-1:0]   walk_pos;
  logic [OFF_W-1:0]   walk_offset;
  logic [RCNT_W-1:0]  range_count_reg;
  logic [GLYPH_W-1:0] glyph_count_reg;
  glyph_res_t         glyph_expect_q[$];

  // Stimulus plan for full table loads
  logic [CODE_W-1:0]  plan_first [MAX_RANGES];
  logic [CODE_W-1:0]  plan_last  [MAX_RANGES];

  int  n_errors = 0;
  int  n_lookups = 0;
  int  n_writes = 0;
  int  n_results = 0;
  int  n_hits = 0;
  int  n_cfg = 0;
  int  burst_left = 8;
  bit  pace_on = 1'b1;
  int  hold_cycles = 0;
  int  rx_cycle = 0;
  int  idle_cycles = 0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endtask

  function automatic void predict_item(input glr_item_t it);
    glyph_res_t     res;
    logic [LIVE_W:0] live;
    logic           hit;
    logic           done;
    int             g;
    if (it.cmd == CMD_WRITE) begin
      span_first[it.slot] = it.first;
      span_last[it.slot]  = it.last;
      walk_pos    = '0;
      walk_offset = OFF_W'(0) - {2'b00, span_first[0]};
      return;
    end
    if (range_count_reg == 0) live = 1;
    else if (range_count_reg > MAX_RANGES) live = MAX_RANGES;
    else live = range_count_reg;
    hit  = 1'b0;
    done = 1'b0;
    while (!done) begin
      if (it.code > span_last[walk_pos]) begin
        if (int'(walk_pos) + 1 < int'(live)) begin
          walk_offset = walk_offset + {2'b00, span_last[walk_pos]} + 18'd1;
          walk_pos    = walk_pos + 1'b1;
          walk_offset = walk_offset - {2'b00, span_first[walk_pos]};
          if (it.code < span_first[walk_pos]) done = 1'b1;
        end else begin
          done = 1'b1;
        end
      end else if (it.code < span_first[walk_pos]) begin
        if (walk_pos > 0) begin
          walk_offset = walk_offset + {2'b00, span_first[walk_pos]};
          walk_pos    = walk_pos - 1'b1;
          walk_offset = walk_offset - {2'b00, span_last[walk_pos]} - 18'd1;
          if (it.code > span_last[walk_pos]) done = 1'b1;
        end else begin
          done = 1'b1;
        end
      end else begin
        hit  = 1'b1;
        done = 1'b1;
      end
    end
    res.glyph = glyph_count_reg - 16'd1;
    res.found = 1'b0;
    if (hit) begin
      g = int'(it.code) + int'($signed(walk_offset));
      if (g >= 0 && g < int'(glyph_count_reg)) begin
        res.glyph = g[GLYPH_W-1:0];
        res.found = 1'b1;
      end
    end
    glyph_expect_q.push_back(res);
  endfunction

  task automatic send_item(input glr_item_t it);
    s_valid <= 1'b1;
    s_data  <= {4'b0000, it.last, it.first, it.slot, it.code};
    s_user  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_item(it);
    if (it.cmd == CMD_WRITE) n_writes++;
    else n_lookups++;
    if (pace_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        s_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                 : $urandom_range(1, 10);
      end
    end
  endtask

  task automatic lookup(input logic [CODE_W-1:0] code);
    glr_item_t it;
    it.cmd   = CMD_LOOKUP;
    it.code  = code;
    it.slot  = SLOT_W'($urandom);
    it.first = CODE_W'($urandom);
    it.last  = CODE_W'($urandom);
    send_item(it);
  endtask

  task automatic write_span(input int slot, input logic [CODE_W-1:0] first,
                            input logic [CODE_W-1:0] last);
    glr_item_t it;
    it.cmd   = CMD_WRITE;
    it.code  = CODE_W'($urandom);
    it.slot  = SLOT_W'(slot);
    it.first = first;
    it.last  = last;
    send_item(it);
  endtask

  // Drop valid, drain results, then cover the walk of a resultless write
  task automatic settle();
    if (s_valid) s_valid <= 1'b0;
    while (glyph_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic addr, input logic [GLYPH_W-1:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_addr  <= addr;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    if (addr == CFG_RANGE_COUNT) range_count_reg = data[RCNT_W-1:0];
    else glyph_count_reg = data;
    n_cfg++;
  endtask

  task automatic load_plan();
    for (int i = 0; i < MAX_RANGES; i++) write_span(i, plan_first[i], plan_last[i]);
  endtask

  task automatic build_ordered_plan(output int total);
    int pos;
    int len;
    int gap;
    pos   = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, 300);
    total = 0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 3000);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 900);
      if (pos > 65535) pos = 65535;
      plan_first[i] = pos[CODE_W-1:0];
      if (pos + len > 65535 || (i == MAX_RANGES - 1 && $urandom_range(0, 1) == 1))
        plan_last[i] = 16'hFFFF;
      else
        plan_last[i] = CODE_W'(pos + len);
      total += int'(plan_last[i]) - int'(plan_first[i]) + 1;
      pos = int'(plan_last[i]) + 1 + gap;
    end
  endtask

  task automatic build_scrambled_plan();
    for (int i = 0; i < MAX_RANGES; i++) begin
      plan_first[i] = CODE_W'($urandom);
      plan_last[i]  = CODE_W'($urandom);
    end
  endtask

  // Output side: stall pattern, long hold-off, result compare
  always @(posedge clk_i) begin
    glyph_res_t exp_res;
    rx_cycle++;
    if (rst_n && m_axis_tvalid_o === 1'b1 && m_ready) begin
      n_results++;
      if (glyph_expect_q.size() == 0) begin
        flag_error($sformatf("unexpected result glyph=%0d found=%0b",
                             m_axis_tdata_o, m_axis_tuser_o));
      end else begin
        exp_res = glyph_expect_q.pop_front();
        if (exp_res.found) n_hits++;
        if (m_axis_tdata_o !== exp_res.glyph || m_axis_tuser_o !== exp_res.found)
          flag_error($sformatf("glyph exp=%0d act=%0d, found exp=%0b act=%0b",
                               exp_res.glyph, m_axis_tdata_o, exp_res.found,
                               m_axis_tuser_o));
      end
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      m_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 300) % 4)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 1) == 1);
        2: m_ready <= ((rx_cycle % 3) != 0);
        default: m_ready <= ($urandom_range(0, 4) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((s_valid && s_axis_tready_o === 1'b1) || (m_axis_tvalid_o === 1'b1 && m_ready) ||
        (cfg_valid && cfg_ready_o === 1'b1))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic test_table_load();
    write_reg(CFG_RANGE_COUNT, 16'd16);
    write_reg(CFG_GLYPH_COUNT, 16'hFFFF);
    for (int i = 0; i < MAX_RANGES; i++) begin
      plan_first[i] = CODE_W'(i * 4096 + ((i == 0) ? 0 : 8));
      plan_last[i]  = (i == MAX_RANGES - 1) ? 16'hFFFF : CODE_W'(i * 4096 + 4087);
    end
    load_plan();
  endtask

  task automatic test_directed_lookups();
    lookup(16'd0);
    lookup(16'd100);
    lookup(16'd4095);
    lookup(16'd4104);
    lookup(16'hFFFF);
    lookup(16'd61440);
    lookup(16'd30000);
    lookup(16'd0);
    lookup(16'hFFFF);
    lookup(16'd12345);
  endtask

  task automatic test_glyph_limits();
    write_reg(CFG_GLYPH_COUNT, 16'd100);
    lookup(16'd50);
    lookup(16'd200);
    lookup(16'd5000);
    write_reg(CFG_GLYPH_COUNT, 16'd0);
    lookup(16'd10);
    write_reg(CFG_GLYPH_COUNT, 16'd1);
    lookup(16'd0);
    write_reg(CFG_GLYPH_COUNT, 16'hFFFF);
  endtask

  task automatic test_range_count_limits();
    lookup(16'd32868);
    write_reg(CFG_RANGE_COUNT, 16'd2);
    lookup(16'd49252);
    lookup(16'd5000);
    write_reg(CFG_RANGE_COUNT, 16'd0);
    lookup(16'd5000);
    lookup(16'd0);
    lookup(16'd9000);
    write_reg(CFG_RANGE_COUNT, 16'd31);
    lookup(16'hFFFF);
    write_reg(CFG_RANGE_COUNT, 16'hFFF0);
    lookup(16'd100);
    write_reg(CFG_RANGE_COUNT, 16'd16);
  endtask

  task automatic test_malformed_table();
    for (int i = 0; i < MAX_RANGES; i++) begin
      plan_first[i] = '0;
      plan_last[i]  = (i == MAX_RANGES - 1) ? 16'hFFFF : CODE_W'(60000 + i * 300);
    end
    load_plan();
    lookup(16'hFFFF);
    lookup(16'd100);
    lookup(16'd64000);
    write_span(MAX_RANGES - 1, 16'hFFFF, 16'd0);
    write_span(3, 16'd70, 16'd20);
    lookup(16'hFFFF);
    lookup(16'd50);
  endtask

  task automatic test_random_traffic();
    int        total;
    int        slot;
    int        k;
    int        lo;
    int        hi;
    glr_item_t it;
    for (int phase = 0; phase < 3; phase++) begin
      settle();
      if ($urandom_range(0, 4) == 0) begin
        build_scrambled_plan();
        total = 65535;
      end else begin
        build_ordered_plan(total);
      end
      case ($urandom_range(0, 4))
        0: write_reg(CFG_RANGE_COUNT, 16'd16);
        1: write_reg(CFG_RANGE_COUNT, GLYPH_W'($urandom_range(1, 16)));
        2: write_reg(CFG_RANGE_COUNT, 16'd0);
        3: write_reg(CFG_RANGE_COUNT, GLYPH_W'($urandom_range(17, 31)));
        default: write_reg(CFG_RANGE_COUNT, GLYPH_W'($urandom));
      endcase
      case ($urandom_range(0, 6))
        0, 1, 2: write_reg(CFG_GLYPH_COUNT, GLYPH_W'((total + 1 > 65535) ? 65535 : total + 1));
        3: write_reg(CFG_GLYPH_COUNT, 16'hFFFF);
        4: write_reg(CFG_GLYPH_COUNT, GLYPH_W'($urandom_range(1, 65535)));
        5: write_reg(CFG_GLYPH_COUNT, GLYPH_W'($urandom_range(1, 200)));
        default: write_reg(CFG_GLYPH_COUNT, 16'd0);
      endcase
      load_plan();
      for (int n = 0; n < 80; n++) begin
        if ($urandom_range(0, 99) < 8) begin
          slot = $urandom_range(0, MAX_RANGES - 1);
          if ($urandom_range(0, 1) == 1)
            write_span(slot, span_first[slot], span_last[slot]);
          else
            write_span(slot, CODE_W'($urandom), CODE_W'($urandom));
        end else begin
          k = $urandom_range(0, 9);
          if (k < 7) slot = int'(walk_pos) + $urandom_range(0, 2) - 1;
          else slot = $urandom_range(0, MAX_RANGES - 1);
          if (slot < 0) slot = 0;
          if (slot > MAX_RANGES - 1) slot = MAX_RANGES - 1;
          lo = int'(span_first[slot]);
          hi = int'(span_last[slot]);
          it.cmd   = CMD_LOOKUP;
          it.slot  = SLOT_W'($urandom);
          it.first = CODE_W'($urandom);
          it.last  = CODE_W'($urandom);
          case (k)
            0, 1, 2, 3, 4, 7: it.code = CODE_W'($urandom_range(lo, hi));
            5: it.code = CODE_W'(hi + 1);
            6: it.code = CODE_W'(lo - 1);
            8: it.code = CODE_W'($urandom);
            default: it.code = ($urandom_range(0, 1) == 1) ? 16'hFFFF : 16'h0000;
          endcase
          send_item(it);
        end
      end
    end
  endtask

  task automatic test_backpressure();
    settle();
    pace_on = 1'b0;
    hold_cycles = HOLD_CYCLES;
    for (int n = 0; n < 40; n++) begin
      lookup(CODE_W'($urandom_range(int'(span_first[n % MAX_RANGES]),
                                    int'(span_last[n % MAX_RANGES]))));
    end
    settle();
    pace_on = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);
    range_count_reg = 5'd1;
    glyph_count_reg = 16'd1;
    walk_pos        = '0;
    walk_offset     = '0;
    for (int i = 0; i < MAX_RANGES; i++) begin
      span_first[i] = '0;
      span_last[i]  = '0;
    end
    test_table_load();
    test_directed_lookups();
    test_glyph_limits();
    test_range_count_limits();
    test_malformed_table();
    test_random_traffic();
    test_backpressure();
    test_random_traffic();
    settle();
    if (glyph_expect_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", glyph_expect_q.size()));
    $display("covered %0d lookups (%0d in range) and %0d table writes, %0d register writes",
             n_lookups, n_hits, n_writes, n_cfg);
    $display("checked %0d results on ordered and malformed tables, %0d errors",
             n_results, n_errors);
    if (n_errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
